// File: sv/lse_pkg.sv
// Shared widths, fixed-point constants and sequencer states of the Legendre series evaluator.
`default_nettype none
package lse_pkg;

    // Stream field widths
    localparam int RecW    = 6;
    localparam int OrderW  = 7;
    localparam int CoefW   = 32;
    localparam int PointW  = 18;
    localparam int ValueW  = 48;
    localparam int InDataW = 64;

    // Shared multiplier operand and product widths
    localparam int MulW  = 32;
    localparam int ProdW = 64;

    // Internal datapath widths, sized for the largest supported order
    localparam int RecipW = 25;
    localparam int TW     = 40;
    localparam int NW     = 41;
    localparam int WW     = 39;
    localparam int AccW   = 50;

    // Fixed-point constants
    localparam logic [30:0] POne = 31'h4000_0000;
    localparam logic [16:0] YOne = 17'h1_0000;
    localparam logic signed [AccW-1:0] ValMax = 50'sh0_7FFF_FFFF_FFFF;
    localparam logic signed [AccW-1:0] ValMin = -50'sh0_8000_0000_0000;

    // Sequencer states, one-hot
    typedef enum logic [12:0] {
        S_IDLE = 13'b0000000000001,
        S_KY   = 13'b0000000000010,
        S_T    = 13'b0000000000100,
        S_LP   = 13'b0000000001000,
        S_N    = 13'b0000000010000,
        S_NL   = 13'b0000000100000,
        S_NH   = 13'b0000001000000,
        S_P    = 13'b0000010000000,
        S_W    = 13'b0000100000000,
        S_BL   = 13'b0001000000000,
        S_BH   = 13'b0010000000000,
        S_ACC  = 13'b0100000000000,
        S_DONE = 13'b1000000000000
    } t_state;

endpackage
`default_nettype wire

// File: sv/lse_mul.sv
// Shared unsigned multiplier with a registered product.
`default_nettype none
module lse_mul (
    input  wire logic                      i_clk,
    input  wire logic [lse_pkg::MulW-1:0]  i_a,
    input  wire logic [lse_pkg::MulW-1:0]  i_b,
    output logic      [lse_pkg::ProdW-1:0] o_prod
);

    logic [lse_pkg::ProdW-1:0] r_prod;

    // Register every product; the sequencer picks it up in the following cycle
    always_ff @(posedge i_clk) begin
        r_prod <= lse_pkg::ProdW'(i_a) * lse_pkg::ProdW'(i_b);
    end

    assign o_prod = r_prod;

endmodule
`default_nettype wire

// File: sv/legendre_series_evaluator_core.sv
// Top level: coefficient store, recurrence sequencer and series accumulator.
//
// Channel   Dir  Handshake                         Payload
// s_axis    in   i_s_axis_tvalid / o_s_axis_tready tuser kind, tdata record..point
// m_axis    out  o_m_axis_tvalid / i_m_axis_tready tdata value, tuser saturated
// cfg       in   i_cfg_we (no wait)                i_cfg_wdata highest_order
//
// A coefficient write is stored on its transfer. An evaluate runs orders 0 to top, and no
// new transfer is taken until it ends; top is highest_order limited to MAX_ORDER. Every order
// above zero runs eight products through the one shared 32x32 multiplier, order 0 only three.
// Reset clears the sequencer, the output valid and highest_order; the store is
// not cleared. A result waiting at the output does not block new transfers;
// only the finish of the next evaluate waits for the output register to free up.
`default_nettype none
module legendre_series_evaluator_core #(
    parameter int RECORDS   = 64,
    parameter int MAX_ORDER = 64
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Input stream
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    // tdata: record[5:0], order[12:6], coefficient[44:13], point[62:45], zero[63]
    input  wire logic [63:0] i_s_axis_tdata,
    // tuser: kind[0]
    input  wire logic        i_s_axis_tuser,
    // Output stream
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    // tdata: value[47:0]
    output logic [47:0]      o_m_axis_tdata,
    // tuser: saturated[0]
    output logic             o_m_axis_tuser,
    // Configuration
    input  wire logic        i_cfg_we,
    input  wire logic [6:0]  i_cfg_wdata
);

    localparam int Row   = MAX_ORDER + 1;
    localparam int Depth = RECORDS * Row;
    localparam int AW    = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int LW    = $clog2(Row);

    // Input field unpacking
    logic                                 w_in_xfer;
    logic                                 w_kind;
    logic [lse_pkg::RecW-1:0]             w_rec;
    logic [lse_pkg::OrderW-1:0]           w_ord;
    logic [lse_pkg::CoefW-1:0]            w_coef;
    logic signed [lse_pkg::PointW-1:0]    w_point;
    logic                                 w_rec_ok;
    logic                                 w_ord_ok;
    logic [31:0]                          w_wr_lin;
    logic [31:0]                          w_base_lin;
    logic [LW-1:0]                        w_top;
    logic [16:0]                          w_y_mag;
    logic                                 w_y_neg;

    // Sequencer and datapath registers
    lse_pkg::t_state                      r_state;
    logic [6:0]                           r_cfg_order;
    logic [LW-1:0]                        r_l;
    logic [LW-1:0]                        r_top;
    logic [AW-1:0]                        r_base;
    logic [16:0]                          r_y_mag;
    logic                                 r_y_neg;
    logic [30:0]                          r_p_mag;
    logic                                 r_p_neg;
    logic [30:0]                          r_pm1_mag;
    logic                                 r_pm1_neg;
    logic signed [lse_pkg::TW:0]          r_t;
    logic [lse_pkg::NW-1:0]               r_n_mag;
    logic                                 r_n_neg;
    logic [lse_pkg::ProdW-1:0]            r_lo;
    logic [lse_pkg::WW-1:0]               r_w_mag;
    logic                                 r_w_neg;
    logic signed [lse_pkg::AccW-1:0]      r_acc;
    logic [lse_pkg::CoefW-1:0]            r_rd;
    logic                                 r_out_valid;
    logic [lse_pkg::ValueW-1:0]           r_out_value;
    logic                                 r_out_sat;

    // Coefficient store
    logic [lse_pkg::CoefW-1:0]            r_mem [0:Depth-1];

    // Reciprocal table, round(2^24 / l)
    logic [lse_pkg::RecipW-1:0]           w_recip [0:MAX_ORDER];

    // Shared multiplier hookup
    logic [lse_pkg::MulW-1:0]             w_mul_a;
    logic [lse_pkg::MulW-1:0]             w_mul_b;
    logic [lse_pkg::ProdW-1:0]            w_prod;

    // Per-step arithmetic
    logic [lse_pkg::TW-1:0]               w_t_mag;
    logic signed [lse_pkg::TW:0]          w_t;
    logic signed [lse_pkg::TW+1:0]        w_lp;
    logic signed [lse_pkg::TW+1:0]        w_n;
    logic [lse_pkg::TW+1:0]               w_n_abs;
    logic [65:0]                          w_psum;
    logic [41:0]                          w_pm;
    logic [30:0]                          w_p_new;
    logic                                 w_b_neg;
    logic [lse_pkg::CoefW-1:0]            w_b_mag;
    logic [64:0]                          w_lo_rnd;
    logic [lse_pkg::NW-1:0]               w_term_mag;
    logic signed [lse_pkg::AccW-1:0]      w_term;
    logic [AW-1:0]                        w_rd_addr;
    logic                                 w_out_free;

    // Unpack the input transfer
    assign w_in_xfer = i_s_axis_tvalid & o_s_axis_tready;
    assign w_kind    = i_s_axis_tuser;
    assign w_rec     = i_s_axis_tdata[5:0];
    assign w_ord     = i_s_axis_tdata[12:6];
    assign w_coef    = i_s_axis_tdata[44:13];
    assign w_point   = $signed(i_s_axis_tdata[62:45]);

    // Range checks and store addressing
    assign w_rec_ok   = (32'(w_rec) < 32'(RECORDS));
    assign w_ord_ok   = (32'(w_ord) <= 32'(MAX_ORDER));
    assign w_wr_lin   = 32'(w_rec) * 32'(Row) + 32'(w_ord);
    assign w_base_lin = 32'(w_rec) * 32'(Row);
    assign w_top      = (32'(r_cfg_order) > 32'(MAX_ORDER)) ? LW'(MAX_ORDER)
                                                             : LW'(r_cfg_order);
    assign w_rd_addr  = r_base + AW'(r_l);

    // Clamp the point to [-1, 1] and split into sign and magnitude
    always_comb begin
        if (w_point > 18'sd65536) begin
            w_y_mag = lse_pkg::YOne;
            w_y_neg = 1'b0;
        end else if (w_point < -18'sd65536) begin
            w_y_mag = lse_pkg::YOne;
            w_y_neg = 1'b1;
        end else begin
            w_y_neg = w_point[lse_pkg::PointW-1];
            w_y_mag = w_y_neg ? 17'(-w_point) : w_point[16:0];
        end
    end

    // Build the reciprocal table at elaboration
    assign w_recip[0] = '0;
    for (genvar g = 1; g <= MAX_ORDER; g++) begin : g_recip
        localparam int RecipVal = ((1 << 24) + g / 2) / g;
        assign w_recip[g] = lse_pkg::RecipW'(RecipVal);
    end

    // t = round((2l-1) * y * P(l-1) / 2^16)
    assign w_t_mag = lse_pkg::TW'((w_prod[55:0] + 56'h8000) >> 16);
    assign w_t     = (r_y_neg ^ r_p_neg) ? -$signed({1'b0, w_t_mag})
                                         : $signed({1'b0, w_t_mag});

    // n = t - (l-1) * P(l-2)
    assign w_lp    = r_pm1_neg ? -$signed({4'b0, w_prod[37:0]})
                               : $signed({4'b0, w_prod[37:0]});
    assign w_n     = $signed({r_t[lse_pkg::TW], r_t}) - w_lp;
    assign w_n_abs = w_n[lse_pkg::TW+1] ? (lse_pkg::TW+2)'(-w_n) : w_n;

    // P(l) = round(|n| * recip(l) / 2^24), clamped to one
    assign w_psum  = {w_prod[33:0], 32'h0} + {2'b0, r_lo} + 66'h80_0000;
    assign w_pm    = w_psum[65:24];
    assign w_p_new = (w_pm > 42'(lse_pkg::POne)) ? lse_pkg::POne : w_pm[30:0];

    // Coefficient magnitude and sign from the store read
    assign w_b_neg = r_rd[lse_pkg::CoefW-1];
    assign w_b_mag = w_b_neg ? (~r_rd + 32'd1) : r_rd;

    // Term = round(|w| * |b| / 2^31), from the two partial products
    assign w_lo_rnd   = {1'b0, r_lo} + 65'h4000_0000;
    assign w_term_mag = lse_pkg::NW'({w_prod[38:0], 1'b0}) + lse_pkg::NW'(w_lo_rnd[64:31]);
    assign w_term     = (r_w_neg ^ w_b_neg) ? -$signed(lse_pkg::AccW'(w_term_mag))
                                            : $signed(lse_pkg::AccW'(w_term_mag));

    // Select multiplier operands per step
    always_comb begin
        w_mul_a = '0;
        w_mul_b = '0;
        case (r_state)
            lse_pkg::S_KY: begin
                w_mul_a = 32'({r_l - LW'(1), 1'b1});
                w_mul_b = 32'(r_y_mag);
            end
            lse_pkg::S_T: begin
                w_mul_a = w_prod[31:0];
                w_mul_b = 32'(r_p_mag);
            end
            lse_pkg::S_LP: begin
                w_mul_a = 32'(r_l - LW'(1));
                w_mul_b = 32'(r_pm1_mag);
            end
            lse_pkg::S_NL: begin
                w_mul_a = r_n_mag[31:0];
                w_mul_b = 32'(w_recip[r_l]);
            end
            lse_pkg::S_NH: begin
                w_mul_a = 32'(r_n_mag[lse_pkg::NW-1:32]);
                w_mul_b = 32'(w_recip[r_l]);
            end
            lse_pkg::S_W: begin
                w_mul_a = 32'({r_l, 1'b1});
                w_mul_b = 32'(r_p_mag);
            end
            lse_pkg::S_BL: begin
                w_mul_a = w_prod[31:0];
                w_mul_b = w_b_mag;
            end
            lse_pkg::S_BH: begin
                w_mul_a = 32'(r_w_mag[lse_pkg::WW-1:32]);
                w_mul_b = w_b_mag;
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    lse_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (w_mul_a),
        .i_b    (w_mul_b),
        .o_prod (w_prod)
    );

    assign w_out_free = ~r_out_valid | i_m_axis_tready;

    // Sequencer and configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= lse_pkg::S_IDLE;
            r_cfg_order <= '0;
        end else begin
            if (i_cfg_we) begin
                r_cfg_order <= i_cfg_wdata;
            end
            case (r_state)
                lse_pkg::S_IDLE: begin
                    if (w_in_xfer && w_kind) begin
                        r_state <= w_rec_ok ? lse_pkg::S_W : lse_pkg::S_DONE;
                    end
                end
                lse_pkg::S_KY:  r_state <= lse_pkg::S_T;
                lse_pkg::S_T:   r_state <= lse_pkg::S_LP;
                lse_pkg::S_LP:  r_state <= lse_pkg::S_N;
                lse_pkg::S_N:   r_state <= lse_pkg::S_NL;
                lse_pkg::S_NL:  r_state <= lse_pkg::S_NH;
                lse_pkg::S_NH:  r_state <= lse_pkg::S_P;
                lse_pkg::S_P:   r_state <= lse_pkg::S_W;
                lse_pkg::S_W:   r_state <= lse_pkg::S_BL;
                lse_pkg::S_BL:  r_state <= lse_pkg::S_BH;
                lse_pkg::S_BH:  r_state <= lse_pkg::S_ACC;
                lse_pkg::S_ACC: begin
                    r_state <= (r_l == r_top) ? lse_pkg::S_DONE : lse_pkg::S_KY;
                end
                lse_pkg::S_DONE: begin
                    if (w_out_free) begin
                        r_state <= lse_pkg::S_IDLE;
                    end
                end
                default: r_state <= lse_pkg::S_IDLE;
            endcase
        end
    end

    // Output valid: raise when a sum is loaded, drop after its transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == lse_pkg::S_DONE && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (r_out_valid && i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            lse_pkg::S_IDLE: begin
                r_l       <= '0;
                r_top     <= w_top;
                r_base    <= AW'(w_base_lin);
                r_y_mag   <= w_y_mag;
                r_y_neg   <= w_y_neg;
                r_p_mag   <= lse_pkg::POne;
                r_p_neg   <= 1'b0;
                r_pm1_mag <= '0;
                r_pm1_neg <= 1'b0;
                r_acc     <= '0;
            end
            lse_pkg::S_LP: begin
                r_t <= w_t;
            end
            lse_pkg::S_N: begin
                r_n_neg <= w_n[lse_pkg::TW+1];
                r_n_mag <= w_n_abs[lse_pkg::NW-1:0];
            end
            lse_pkg::S_NH: begin
                r_lo <= w_prod;
            end
            lse_pkg::S_P: begin
                r_pm1_mag <= r_p_mag;
                r_pm1_neg <= r_p_neg;
                r_p_mag   <= w_p_new;
                r_p_neg   <= r_n_neg;
            end
            lse_pkg::S_BL: begin
                r_w_mag <= w_prod[lse_pkg::WW-1:0];
                r_w_neg <= r_p_neg;
            end
            lse_pkg::S_BH: begin
                r_lo <= w_prod;
            end
            lse_pkg::S_ACC: begin
                r_acc <= r_acc + w_term;
                if (r_l != r_top) begin
                    r_l <= r_l + LW'(1);
                end
            end
            lse_pkg::S_DONE: begin
                if (w_out_free) begin
                    if (r_acc > lse_pkg::ValMax) begin
                        r_out_value <= lse_pkg::ValMax[lse_pkg::ValueW-1:0];
                        r_out_sat   <= 1'b1;
                    end else if (r_acc < lse_pkg::ValMin) begin
                        r_out_value <= lse_pkg::ValMin[lse_pkg::ValueW-1:0];
                        r_out_sat   <= 1'b1;
                    end else begin
                        r_out_value <= r_acc[lse_pkg::ValueW-1:0];
                        r_out_sat   <= 1'b0;
                    end
                end
            end
            default: begin
                r_l <= r_l;
            end
        endcase
    end

    // Store write on a coefficient transfer with record and order in range, read once per order
    always_ff @(posedge i_clk) begin
        if (w_in_xfer && !w_kind && w_rec_ok && w_ord_ok) begin
            r_mem[AW'(w_wr_lin)] <= w_coef;
        end
        if (r_state == lse_pkg::S_W) begin
            r_rd <= r_mem[w_rd_addr];
        end
    end

    // Drive the ports
    assign o_s_axis_tready = (r_state == lse_pkg::S_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_value;
    assign o_m_axis_tuser  = r_out_sat;

endmodule
`default_nettype wire

// File: tb/legendre_series_evaluator_core_test.sv
// Testbench for the Legendre series evaluator: directed table, then predicted random phases.
module legendre_series_evaluator_core_test;

    localparam int RECORDS      = 64;
    localparam int MAX_ORDER    = 64;
    localparam int HOLD_CYCLES  = 2000;
    localparam int QUIET_LIMIT  = 20000;
    localparam int DRAIN_CYCLES = 100;
    localparam int CFG_SETTLE   = 16;

    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_EVAL  = 1'b1;

    localparam longint ONE_Q30 = 64'sd1 << 30;
    localparam longint SUM_MAX = (64'sd1 << 47) - 64'sd1;
    localparam longint SUM_MIN = -(64'sd1 << 47);

    // Order settings per random phase; 127 acts as the largest order
    localparam int NUM_PHASES = 8;
    localparam int PHASE_TOP   [NUM_PHASES] = '{1, 5, 127, 2, 64, 12, 0, 3};
    localparam int PHASE_ITEMS [NUM_PHASES] = '{40, 40, 12, 40, 12, 30, 30, 40};

    typedef struct packed {
        logic [lse_pkg::ValueW-1:0] value;
        logic                       saturated;
    } t_series;

    typedef struct packed {
        logic                       kind;
        logic [lse_pkg::RecW-1:0]   rec;
        logic [lse_pkg::OrderW-1:0] ord;
        logic [lse_pkg::CoefW-1:0]  coef;
        logic [lse_pkg::PointW-1:0] pt;
        logic                       has_sum;
        logic [lse_pkg::ValueW-1:0] value;
    } t_stim_row;

    // Directed rows run with the reset order setting, so only order 0 is summed
    localparam int NUM_DIRECTED = 18;
    localparam t_stim_row DIRECTED [NUM_DIRECTED] = '{
        '{KIND_WRITE, 6'd0,  7'd0,   32'h7FFF_FFFF, 18'h0_0000, 1'b0, 48'h0},
        '{KIND_EVAL,  6'd0,  7'd0,   32'h0,         18'h1_0000, 1'b1, 48'h0000_4000_0000},
        '{KIND_EVAL,  6'd0,  7'd0,   32'h0,         18'h3_0000, 1'b1, 48'h0000_4000_0000},
        '{KIND_WRITE, 6'd63, 7'd0,   32'h8000_0000, 18'h0_0000, 1'b0, 48'h0},
        '{KIND_EVAL,  6'd63, 7'd0,   32'h0,         18'h1_FFFF, 1'b1, 48'hFFFF_C000_0000},
        '{KIND_EVAL,  6'd63, 7'd0,   32'h0,         18'h2_0000, 1'b1, 48'hFFFF_C000_0000},
        '{KIND_WRITE, 6'd1,  7'd0,   32'h0,         18'h0_0000, 1'b0, 48'h0},
        // orders past the store must be dropped, not alias into the next record
        '{KIND_WRITE, 6'd0,  7'd65,  32'h1234_5678, 18'h0_0000, 1'b0, 48'h0},
        '{KIND_WRITE, 6'd0,  7'd127, 32'hDEAD_BEEF, 18'h0_0000, 1'b0, 48'h0},
        '{KIND_EVAL,  6'd1,  7'd0,   32'h0,         18'h0_0000, 1'b1, 48'h0},
        '{KIND_WRITE, 6'd0,  7'd0,   32'h0000_0001, 18'h0_0000, 1'b0, 48'h0},
        '{KIND_EVAL,  6'd0,  7'd0,   32'h0,         18'h0_0000, 1'b1, 48'h0000_0000_0001},
        '{KIND_WRITE, 6'd0,  7'd0,   32'hFFFF_FFFF, 18'h0_0000, 1'b0, 48'h0},
        '{KIND_EVAL,  6'd0,  7'd0,   32'h0,         18'h0_8000, 1'b1, 48'hFFFF_FFFF_FFFF},
        '{KIND_WRITE, 6'd0,  7'd0,   32'h0000_0003, 18'h0_0000, 1'b0, 48'h0},
        '{KIND_EVAL,  6'd0,  7'd0,   32'h0,         18'h3_FFFF, 1'b1, 48'h0000_0000_0002},
        '{KIND_WRITE, 6'd0,  7'd64,  32'h7FFF_FFFF, 18'h0_0000, 1'b0, 48'h0},
        '{KIND_EVAL,  6'd0,  7'd0,   32'h0,         18'h0_04D2, 1'b0, 48'h0}
    };

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_s_axis_tvalid = 1'b0;
    logic [63:0]       i_s_axis_tdata = '0;
    logic              i_s_axis_tuser = 1'b0;
    logic              i_m_axis_tready = 1'b0;
    logic              i_cfg_we = 1'b0;
    logic [6:0]        i_cfg_wdata = '0;
    wire               o_s_axis_tready;
    wire               o_m_axis_tvalid;
    wire  [47:0]       o_m_axis_tdata;
    wire               o_m_axis_tuser;

    // Predictor state
    logic signed [lse_pkg::CoefW-1:0] coef_store   [RECORDS][MAX_ORDER+1];
    bit                               coef_written [RECORDS][MAX_ORDER+1];
    logic [lse_pkg::OrderW-1:0]       order_setting = '0;
    t_series                          expected_sums [$];

    bit idle_on = 1'b1;
    bit hold_request = 1'b0;
    int errors = 0;
    int quiet_cycles = 0;
    int writes_sent = 0;
    int evals_sent = 0;
    int results_seen = 0;
    int settings_used = 0;

    legendre_series_evaluator_core #(
        .RECORDS  (RECORDS),
        .MAX_ORDER(MAX_ORDER)
    ) u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_axis_tvalid(i_s_axis_tvalid),
        .o_s_axis_tready(o_s_axis_tready),
        .i_s_axis_tdata (i_s_axis_tdata),
        .i_s_axis_tuser (i_s_axis_tuser),
        .o_m_axis_tvalid(o_m_axis_tvalid),
        .i_m_axis_tready(i_m_axis_tready),
        .o_m_axis_tdata (o_m_axis_tdata),
        .o_m_axis_tuser (o_m_axis_tuser),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    function automatic longint unsigned magnitude(input longint x);
        return (x < 0) ? -x : x;
    endfunction

    function automatic int summed_top();
        return (order_setting > MAX_ORDER) ? MAX_ORDER : int'(order_setting);
    endfunction

    // Build P_l by recurrence and accumulate the weighted series for one record
    function automatic t_series legendre_sum(input logic [lse_pkg::RecW-1:0] rec,
                                             input logic signed [lse_pkg::PointW-1:0] pt);
        longint            y, p, p_prev, p_next, t, n, w, acc;
        longint unsigned   rcp, m;
        logic [95:0]       prod;
        t_series           res;
        y = longint'(pt);
        if (y > 65536) y = 65536;
        if (y < -65536) y = -65536;
        p = ONE_Q30;
        p_prev = 0;
        acc = 0;
        for (int l = 0; l <= summed_top(); l++) begin
            if (l > 0) begin
                t = longint'(2 * l - 1) * (y * p);
                m = (magnitude(t) + (64'd1 << 15)) >> 16;
                t = (t < 0) ? -longint'(m) : longint'(m);
                n = t - longint'(l - 1) * p_prev;
                rcp = ((64'd1 << 24) + 64'(l >> 1)) / 64'(l);
                m = (magnitude(n) * rcp + (64'd1 << 23)) >> 24;
                p_next = (n < 0) ? -longint'(m) : longint'(m);
                if (p_next > ONE_Q30) p_next = ONE_Q30;
                if (p_next < -ONE_Q30) p_next = -ONE_Q30;
                p_prev = p;
                p = p_next;
            end
            w = longint'(2 * l + 1) * p;
            prod = (96'(magnitude(w)) * 96'(magnitude(longint'(coef_store[rec][l])))
                    + (96'd1 << 30)) >> 31;
            acc += ((w < 0) != (coef_store[rec][l] < 0)) ? -longint'(prod[63:0])
                                                         : longint'(prod[63:0]);
        end
        res.saturated = 1'b0;
        if (acc > SUM_MAX) begin
            acc = SUM_MAX;
            res.saturated = 1'b1;
        end
        if (acc < SUM_MIN) begin
            acc = SUM_MIN;
            res.saturated = 1'b1;
        end
        res.value = acc[lse_pkg::ValueW-1:0];
        return res;
    endfunction

    // Apply one accepted item to the predictor
    function automatic void step_model(input logic kind,
                                       input logic [lse_pkg::RecW-1:0] rec,
                                       input logic [lse_pkg::OrderW-1:0] ord,
                                       input logic [lse_pkg::CoefW-1:0] coef,
                                       input logic [lse_pkg::PointW-1:0] pt);
        if (kind == KIND_WRITE) begin
            if (ord <= MAX_ORDER) begin
                coef_store[rec][ord] = coef;
                coef_written[rec][ord] = 1'b1;
            end
        end else if (rec >= RECORDS) begin
            expected_sums.push_back(t_series'{ {lse_pkg::ValueW{1'b0}}, 1'b0 });
        end else begin
            expected_sums.push_back(legendre_sum(rec, pt));
        end
    endfunction

    function automatic bit record_ready(input int rec);
        for (int l = 0; l <= summed_top(); l++)
            if (!coef_written[rec][l]) return 1'b0;
        return 1'b1;
    endfunction

    // Mostly back to back, some short gaps, a few long ones
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (!idle_on || roll < 70) return 0;
        if (roll < 96) return $urandom_range(1, 4);
        return $urandom_range(20, 80);
    endfunction

    function automatic logic [lse_pkg::CoefW-1:0] rand_coef();
        case ($urandom_range(0, 9))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return lse_pkg::CoefW'($urandom_range(0, 1 << 17) - (1 << 16));
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [lse_pkg::PointW-1:0] rand_point();
        case ($urandom_range(0, 9))
            0: return 18'h1_0000;
            1: return 18'h3_0000;
            // raw code, often outside [-1,1]
            2, 3: return lse_pkg::PointW'($urandom_range(0, (1 << lse_pkg::PointW) - 1));
            default: return lse_pkg::PointW'($urandom_range(0, 131072) - 65536);
        endcase
    endfunction

    // Offer one item and hold it until the transfer; tvalid stays high on return
    task automatic offer_item(input logic kind, input logic [lse_pkg::RecW-1:0] rec,
                              input logic [lse_pkg::OrderW-1:0] ord,
                              input logic [lse_pkg::CoefW-1:0] coef,
                              input logic [lse_pkg::PointW-1:0] pt);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tuser  <= kind;
        i_s_axis_tdata  <= {1'b0, pt, coef, ord, rec};
        do @(posedge i_clk); while (!o_s_axis_tready);
        if (kind == KIND_WRITE) writes_sent++;
        else evals_sent++;
    endtask

    task automatic run_item(input logic kind, input logic [lse_pkg::RecW-1:0] rec,
                            input logic [lse_pkg::OrderW-1:0] ord,
                            input logic [lse_pkg::CoefW-1:0] coef,
                            input logic [lse_pkg::PointW-1:0] pt);
        offer_item(kind, rec, ord, coef, pt);
        step_model(kind, rec, ord, coef, pt);
    endtask

    // Drain the block, then write the order register
    task automatic set_highest_order(input logic [lse_pkg::OrderW-1:0] setting);
        i_s_axis_tvalid <= 1'b0;
        while (expected_sums.size() != 0) @(posedge i_clk);
        repeat (CFG_SETTLE) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= setting;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        order_setting = setting;
        settings_used++;
    endtask

    // Mostly complete-record evaluations and rewrites, plus dropped writes
    task automatic random_phase(input int n_items);
        logic [lse_pkg::RecW-1:0] ready_recs [$];
        logic [lse_pkg::RecW-1:0] rec;
        int                       roll;
        for (int k = 0; k < n_items; k++) begin
            roll = $urandom_range(0, 99);
            if (roll < 45) begin
                ready_recs = {};
                for (int r = 0; r < RECORDS; r++)
                    if (record_ready(r)) ready_recs.push_back(r[lse_pkg::RecW-1:0]);
                if (ready_recs.size() != 0 &&
                    $urandom_range(0, 9) < ((summed_top() > 12) ? 9 : 7)) begin
                    rec = ready_recs[$urandom_range(0, ready_recs.size() - 1)];
                end else begin
                    rec = lse_pkg::RecW'($urandom_range(0, RECORDS - 1));
                    // fill every missing order before the record is evaluated
                    for (int l = 0; l <= summed_top(); l++)
                        if (!coef_written[rec][l])
                            run_item(KIND_WRITE, rec, lse_pkg::OrderW'(l), rand_coef(),
                                     lse_pkg::PointW'($urandom_range(0,
                                         (1 << lse_pkg::PointW) - 1)));
                end
                run_item(KIND_EVAL, rec, lse_pkg::OrderW'($urandom_range(0, 127)),
                         $urandom, rand_point());
            end else if (roll < 75) begin
                run_item(KIND_WRITE, lse_pkg::RecW'($urandom_range(0, RECORDS - 1)),
                         lse_pkg::OrderW'($urandom_range(0, summed_top())), rand_coef(),
                         lse_pkg::PointW'($urandom_range(0, (1 << lse_pkg::PointW) - 1)));
            end else begin
                // any order, including ones past the store that must be dropped
                run_item(KIND_WRITE, lse_pkg::RecW'($urandom_range(0, RECORDS - 1)),
                         lse_pkg::OrderW'($urandom_range(0, 127)), rand_coef(),
                         lse_pkg::PointW'($urandom_range(0, (1 << lse_pkg::PointW) - 1)));
            end
        end
    endtask

    // Output side: random stalls, and one long hold-off on request
    initial begin : result_sink
        int gap;
        forever begin
            if (hold_request) begin
                hold_request = 1'b0;
                i_m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                gap = pick_gap();
                if (gap > 0) begin
                    i_m_axis_tready <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end else begin
                    i_m_axis_tready <= 1'b1;
                    @(posedge i_clk);
                end
            end
        end
    end

    // Compare each output transfer with the oldest pending sum
    always @(posedge i_clk) begin : result_check
        t_series want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            results_seen++;
            if (expected_sums.size() == 0) begin
                $display("%0t: result with nothing pending, actual value %h saturated %b",
                         $time, o_m_axis_tdata, o_m_axis_tuser);
                errors++;
            end else begin
                want = expected_sums.pop_front();
                if (o_m_axis_tdata !== want.value) begin
                    $display("%0t: value mismatch, expected %h actual %h",
                             $time, want.value, o_m_axis_tdata);
                    errors++;
                end
                if (o_m_axis_tuser !== want.saturated) begin
                    $display("%0t: saturated mismatch, expected %b actual %b",
                             $time, want.saturated, o_m_axis_tuser);
                    errors++;
                end
            end
        end
    end

    // End the run when nothing has moved for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_axis_tvalid && o_s_axis_tready) ||
            (o_m_axis_tvalid && i_m_axis_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: no transfer for %0d cycles, %0d sums pending",
                     $time, quiet_cycles, expected_sums.size());
            $display("legendre_series_evaluator_core_test: errors");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : stimulus
        t_stim_row row;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Walk the directed table
        for (int i = 0; i < NUM_DIRECTED; i++) begin
            row = DIRECTED[i];
            offer_item(row.kind, row.rec, row.ord, row.coef, row.pt);
            if (row.kind == KIND_EVAL && row.has_sum)
                expected_sums.push_back(t_series'{row.value, 1'b0});
            else
                step_model(row.kind, row.rec, row.ord, row.coef, row.pt);
        end

        // Random phases, one order setting each
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            idle_on = (ph != 3 && ph != 6);
            set_highest_order(lse_pkg::OrderW'(PHASE_TOP[ph]));
            if (ph == 1) hold_request = 1'b1;
            random_phase(PHASE_ITEMS[ph]);
        end

        i_s_axis_tvalid <= 1'b0;
        while (expected_sums.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Covered %0d coefficient writes and %0d evaluations, %0d results checked,",
                 writes_sent, evals_sent, results_seen);
        $display("over %0d order settings, odd points, dropped writes, a %0d-cycle hold-off.",
                 settings_used, HOLD_CYCLES);
        if (errors == 0)
            $display("legendre_series_evaluator_core_test: clean");
        else
            $display("legendre_series_evaluator_core_test: errors");
        $finish;
    end

endmodule
